// ===== rtl/pipm_pkg.sv =====
// Package: constants, types and state encodings for the pulse interval power meter.
package pipm_pkg;

  // Register map
  localparam int unsigned REG_PPU = 0;

  // Field and datapath widths
  localparam int unsigned PPU_W  = 14;  // pulses-per-unit register
  localparam int unsigned IW     = 39;  // interval bits used by the divisor
  localparam int unsigned PW     = IW + PPU_W;  // interval * pulses_per_unit
  localparam int unsigned QW     = 39;  // rate quotient
  localparam int unsigned CNT_W  = 6;   // step counter of the serial unit

  localparam logic [PPU_W-1:0] PPU_RESET = PPU_W'(100);
  // 1000 ms/s * 3.6e6 J/kWh * 100 centiwatt/W
  localparam logic [QW-1:0]    RATE_NUM  = 39'd360000000000;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_CALC,
    ST_DONE
  } meter_state_e;

  typedef enum logic [1:0] {
    U_IDLE,
    U_MUL,
    U_DIV
  } unit_state_e;

  // Request to the serial rate unit
  typedef struct packed {
    logic             start;
    logic [IW-1:0]    ivl;
    logic [PPU_W-1:0] ppu;
  } rate_req_t;

  // Answer from the serial rate unit
  typedef struct packed {
    logic          done;
    logic [QW-1:0] quo;
  } rate_rsp_t;

endpackage

// ===== rtl/pulse_interval_power_meter.sv =====
// Top level: pulse interval power meter with APB register and serial rate unit.
//
// Usage: each input beat on in_valid_i/in_ready_o carries the millisecond
// timestamp of one meter pulse edge. Each pulse gives exactly one output beat
// on out_valid_o/out_ready_i with the pulse number, interval, rate in
// hundredths of a watt, the indicator level before the pulse and the
// zero-interval flag. The first pulse after reset (or after the count wraps)
// gives no rate and leaves the stored timestamp alone.
// Flow: a first pulse needs no rate and goes on to the output register. Any
// other pulse is registered to start the rate unit, which multiplies the
// interval by pulses_per_unit bit-serially, then runs the restoring divide
// (one quotient bit per cycle); the selected rate and then the result are
// registered. The rate unit handles one pulse at a time and the input
// reopens once the result is registered, so no new pulse is taken while one
// is in flight. A new pulse is taken as soon as the last result sits in the
// output register, even while the receiver stalls; a further result then
// waits in the meter until the output register drains.
// Reset clears the stored timestamp, count and indicator, sets
// pulses_per_unit to 100 and empties the output. The register is written
// over APB at byte address 0.
module pulse_interval_power_meter
  import pipm_pkg::*;
#(
  parameter int unsigned STAMP_BITS = 32
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // APB register port
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  // Pulse input
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [31:0] timestamp_ms_i,
  // Result output
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic        rate_valid_o,
  output logic [31:0] pulse_number_o,
  output logic [31:0] interval_ms_o,
  output logic [38:0] rate_centi_o,
  output logic        indicator_o,
  output logic        zero_interval_o
);

  // Width that holds both a timestamp and the 32-bit input
  localparam int unsigned TW = (STAMP_BITS > 32) ? STAMP_BITS : 32;
  // Width that holds both the interval and the rate numerator
  localparam int unsigned CW = (STAMP_BITS > IW) ? STAMP_BITS : IW;

  meter_state_e          state_q, state_d;

  logic [PPU_W-1:0]      ppu_q;
  logic [STAMP_BITS-1:0] last_q;
  logic [31:0]           count_q;
  logic                  ind_q;

  // Per-pulse working values
  logic [STAMP_BITS-1:0] iv_q;
  logic [31:0]           pnum_q;
  logic                  pind_q;
  logic                  first_q;
  logic                  start_q;
  logic [QW-1:0]         prate_q;

  rate_req_t             req;
  rate_rsp_t             rsp;

  logic                  in_fire;
  logic                  out_free;
  logic                  cfg_wr;
  logic [TW-1:0]         ts_ext;
  logic [STAMP_BITS-1:0] now;
  logic [CW-1:0]         iv_ext;
  logic                  iv_zero;
  logic                  iv_big;
  logic [QW-1:0]         rate_sel;
  logic                  load_out;

  // ---------------------------------------------------------------------
  // Register port: single register, no wait states
  // ---------------------------------------------------------------------
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && (paddr[2] == 1'(REG_PPU));
  assign prdata = (paddr[2] == 1'(REG_PPU)) ? 32'(ppu_q) : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ppu_q <= PPU_RESET;
    end else if (cfg_wr) begin
      ppu_q <= pwdata[PPU_W-1:0];
    end
  end

  // ---------------------------------------------------------------------
  // Pulse intake: interval and meter state update at acceptance
  // ---------------------------------------------------------------------
  assign in_ready_o = (state_q == ST_IDLE);
  assign in_fire    = in_valid_i && in_ready_o;
  assign ts_ext     = TW'(timestamp_ms_i);
  assign now        = ts_ext[STAMP_BITS-1:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      last_q  <= '0;
      count_q <= '0;
      ind_q   <= 1'b0;
      start_q <= 1'b0;
      first_q <= 1'b0;
    end else begin
      start_q <= in_fire && (count_q != '0);
      if (in_fire) begin
        first_q <= (count_q == '0);
        count_q <= count_q + 32'd1;
        // A first pulse keeps the stored timestamp and the indicator
        if (count_q != '0) begin
          last_q <= now;
          ind_q  <= ~ind_q;
        end
      end
    end
  end

  // Hold the pulse's values until its result is reported
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      iv_q   <= now - last_q;
      pnum_q <= count_q;
      pind_q <= ind_q;
    end
  end

  // ---------------------------------------------------------------------
  // Serial rate unit
  // ---------------------------------------------------------------------
  assign iv_ext    = CW'(iv_q);
  assign req.start = start_q;
  assign req.ivl   = iv_ext[IW-1:0];
  assign req.ppu   = ppu_q;

  pipm_rate u_rate (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (req),
    .rsp_o  (rsp)
  );

  // Saturate on a zero interval or zero divisor; drop to zero when the
  // interval alone already exceeds the numerator.
  assign iv_zero  = (iv_q == '0);
  assign iv_big   = (iv_ext > CW'(RATE_NUM));
  assign rate_sel = (iv_zero || (ppu_q == '0)) ? RATE_NUM :
                    iv_big                     ? '0       : rsp.quo;

  always_ff @(posedge clk_i) begin
    if (rsp.done) begin
      prate_q <= rate_sel;
    end
  end

  // ---------------------------------------------------------------------
  // Sequencer
  // ---------------------------------------------------------------------
  assign out_free = !out_valid_o || out_ready_i;

  always_comb begin
    state_d  = state_q;
    load_out = 1'b0;
    case (state_q)
      ST_IDLE: begin
        if (in_fire) begin
          state_d = (count_q == '0) ? ST_DONE : ST_CALC;
        end
      end
      ST_CALC: begin
        if (rsp.done) begin
          state_d = ST_DONE;
        end
      end
      ST_DONE: begin
        if (out_free) begin
          load_out = 1'b1;
          state_d  = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_o <= 1'b0;
    end else begin
      state_q <= state_d;
      if (load_out) begin
        out_valid_o <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_o <= 1'b0;
      end
    end
  end

  // Output register
  always_ff @(posedge clk_i) begin
    if (load_out) begin
      rate_valid_o    <= !first_q;
      pulse_number_o  <= pnum_q;
      indicator_o     <= pind_q;
      interval_ms_o   <= first_q ? '0 : iv_ext[31:0];
      rate_centi_o    <= first_q ? '0 : prate_q;
      zero_interval_o <= !first_q && iv_zero;
    end
  end

  // ---------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------
  a_done_in_calc: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp.done |-> (state_q == ST_CALC))
    else $error("rate unit finished outside the calculation phase");

  a_later_pulse_calcs: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_fire && (count_q != '0)) |=> (state_q == ST_CALC) && start_q)
    else $error("later pulse did not start the rate unit");

  a_ind_toggles: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_fire && (count_q != '0)) |=> (ind_q != $past(ind_q)))
    else $error("indicator did not toggle on a later pulse");

  a_first_no_rate: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !rate_valid_o) |->
      ((rate_centi_o == '0) && (interval_ms_o == '0) && !zero_interval_o))
    else $error("first pulse carries a rate");

  a_zero_saturates: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && zero_interval_o) |-> (rate_centi_o == RATE_NUM))
    else $error("zero interval without saturated rate");

endmodule

// ===== rtl/pipm_rate.sv =====
// Bit-serial multiply then restoring divide: RATE_NUM / (ivl * ppu).
module pipm_rate
  import pipm_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  rate_req_t req_i,
  output rate_rsp_t rsp_o
);

  unit_state_e      state_q, state_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic             done_q, done_d;
  logic [IW-1:0]    mcand_q, mcand_d;
  logic [PPU_W-1:0] mplr_q, mplr_d;
  logic [PW-1:0]    acc_q, acc_d;
  logic [PW-1:0]    rem_q, rem_d;
  logic [QW-1:0]    quo_q, quo_d;

  logic [PW:0]      trial;
  logic [PW:0]      diff;
  logic             ge;

  // One quotient bit per cycle
  assign trial = {rem_q, quo_q[QW-1]};
  assign diff  = trial - {1'b0, acc_q};
  assign ge    = (trial >= {1'b0, acc_q});

  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    done_d  = 1'b0;
    mcand_d = mcand_q;
    mplr_d  = mplr_q;
    acc_d   = acc_q;
    rem_d   = rem_q;
    quo_d   = quo_q;
    case (state_q)
      U_IDLE: begin
        if (req_i.start) begin
          mcand_d = req_i.ivl;
          mplr_d  = req_i.ppu;
          acc_d   = '0;
          cnt_d   = CNT_W'(PPU_W - 1);
          state_d = U_MUL;
        end
      end
      U_MUL: begin
        // MSB first: shift the product and add the multiplicand
        acc_d  = {acc_q[PW-2:0], 1'b0} + (mplr_q[PPU_W-1] ? PW'(mcand_q) : '0);
        mplr_d = {mplr_q[PPU_W-2:0], 1'b0};
        if (cnt_q == '0) begin
          rem_d   = '0;
          quo_d   = RATE_NUM;
          cnt_d   = CNT_W'(QW - 1);
          state_d = U_DIV;
        end else begin
          cnt_d = cnt_q - 1'b1;
        end
      end
      U_DIV: begin
        rem_d = ge ? diff[PW-1:0] : trial[PW-1:0];
        quo_d = {quo_q[QW-2:0], ge};
        if (cnt_q == '0) begin
          done_d  = 1'b1;
          state_d = U_IDLE;
        end else begin
          cnt_d = cnt_q - 1'b1;
        end
      end
      default: state_d = U_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= U_IDLE;
      cnt_q   <= '0;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      done_q  <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    mcand_q <= mcand_d;
    mplr_q  <= mplr_d;
    acc_q   <= acc_d;
    rem_q   <= rem_d;
    quo_q   <= quo_d;
  end

  assign rsp_o.done = done_q;
  assign rsp_o.quo  = quo_q;

endmodule

// ===== dv/pulse_meter_checker.sv =====
// Checker: predicts each meter reading and compares it with the output beats of the block.
module pulse_meter_checker
  import pipm_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  input  logic [31:0] prdata,
  input  logic        pready,
  input  logic        in_valid_i,
  input  logic        in_ready_i,
  input  logic [31:0] timestamp_ms_i,
  input  logic        out_valid_i,
  input  logic        out_ready_i,
  input  logic        rate_valid_i,
  input  logic [31:0] pulse_number_i,
  input  logic [31:0] interval_ms_i,
  input  logic [38:0] rate_centi_i,
  input  logic        indicator_i,
  input  logic        zero_interval_i,
  output int          fail_count_o,
  output int          pending_o
);

  localparam logic [2:0] PPU_ADDR = 3'(REG_PPU * 4);

  typedef struct packed {
    logic          rate_valid;
    logic [31:0]   pulse_number;
    logic [31:0]   interval_ms;
    logic [QW-1:0] rate_centi;
    logic          indicator;
    logic          zero_interval;
  } meter_reading_t;

  // Own copy of the meter state and its register
  logic [31:0]      stamp_q;
  logic [31:0]      count_q;
  logic             level_q;
  logic [PPU_W-1:0] ppu_q;

  meter_reading_t expected_readings[$];

  function automatic logic [QW-1:0] rate_for(input logic [31:0] ivl,
                                             input logic [PPU_W-1:0] ppu);
    logic [63:0] divisor;
    if (ivl == '0 || ppu == '0) return RATE_NUM;
    divisor = 64'(ivl) * 64'(ppu);
    return QW'(64'(RATE_NUM) / divisor);
  endfunction

  task automatic predict_pulse(input logic [31:0] stamp, output meter_reading_t r);
    logic [31:0] ivl;
    ivl            = stamp - stamp_q;
    r              = '0;
    r.pulse_number = count_q;
    r.indicator    = level_q;
    if (count_q == '0) begin
      // first pulse: count only, stored stamp stays
      count_q = 32'd1;
    end else begin
      stamp_q         = stamp;
      r.rate_valid    = 1'b1;
      r.interval_ms   = ivl;
      r.rate_centi    = rate_for(ivl, ppu_q);
      r.zero_interval = (ivl == '0);
      count_q         = count_q + 32'd1;
      level_q         = ~level_q;
    end
  endtask

  function automatic int field_differs(input string name, input logic [63:0] want,
                                       input logic [63:0] got);
    if (got === want) return 0;
    $error("%s: expected %0d, got %0d", name, want, got);
    return 1;
  endfunction

  always @(posedge clk_i) begin
    meter_reading_t want;
    if (!rst_ni) begin
      stamp_q      = '0;
      count_q      = '0;
      level_q      = 1'b0;
      ppu_q        = PPU_RESET;
      fail_count_o = 0;
      expected_readings.delete();
    end else begin
      if (psel && penable && pready && paddr == PPU_ADDR) begin
        if (pwrite) begin
          ppu_q = pwdata[PPU_W-1:0];
        end else begin
          fail_count_o += field_differs("pulses_per_unit", 64'(ppu_q), 64'(prdata));
        end
      end
      if (in_valid_i && in_ready_i) begin
        predict_pulse(timestamp_ms_i, want);
        expected_readings.push_back(want);
      end
      if (out_valid_i && out_ready_i) begin
        if (expected_readings.size() == 0) begin
          $error("output beat with no reading expected");
          fail_count_o++;
        end else begin
          want = expected_readings.pop_front();
          fail_count_o += field_differs("rate_valid", 64'(want.rate_valid),
                                        64'(rate_valid_i));
          fail_count_o += field_differs("pulse_number", 64'(want.pulse_number),
                                        64'(pulse_number_i));
          fail_count_o += field_differs("interval_ms", 64'(want.interval_ms),
                                        64'(interval_ms_i));
          fail_count_o += field_differs("rate_centi", 64'(want.rate_centi),
                                        64'(rate_centi_i));
          fail_count_o += field_differs("indicator", 64'(want.indicator),
                                        64'(indicator_i));
          fail_count_o += field_differs("zero_interval", 64'(want.zero_interval),
                                        64'(zero_interval_i));
        end
      end
    end
    pending_o = expected_readings.size();
  end

endmodule

// ===== dv/pulse_interval_power_meter_tb.sv =====
// Testbench top: drives pulses and register writes into the meter and gives the verdict.
module pulse_interval_power_meter_tb;
  import pipm_pkg::*;

  localparam int unsigned CLK_PERIOD    = 12;
  localparam int unsigned RESET_CYCLES  = 11;
  localparam int unsigned MAX_WAIT      = 19;
  // long receiver hold-off, far beyond what the meter can buffer
  localparam int unsigned HOLD_CYCLES   = 800;
  // leave room after the last drain for a stray beat
  localparam int unsigned DRAIN_CYCLES  = 120;
  localparam int unsigned CYCLE_LIMIT   = 400000;
  localparam int unsigned RANDOM_PHASES = 4;
  localparam int unsigned PHASE_PULSES  = 100;
  localparam logic [2:0]  PPU_ADDR      = 3'(REG_PPU * 4);

  logic        clk_i          = 1'b0;
  logic        rst_ni         = 1'b0;
  logic        psel           = 1'b0;
  logic        penable        = 1'b0;
  logic        pwrite         = 1'b0;
  logic [2:0]  paddr          = '0;
  logic [31:0] pwdata         = '0;
  logic [31:0] prdata;
  logic        pready;
  logic        in_valid_i     = 1'b0;
  logic        in_ready_o;
  logic [31:0] timestamp_ms_i = '0;
  logic        out_valid_o;
  logic        out_ready_i    = 1'b0;
  logic        rate_valid_o;
  logic [31:0] pulse_number_o;
  logic [31:0] interval_ms_o;
  logic [38:0] rate_centi_o;
  logic        indicator_o;
  logic        zero_interval_o;

  int fail_count;
  int pending;
  int cycle_cnt = 0;

  // Shared knobs between the sender and the receiver
  bit calm      = 1'b0;  // both sides run without gaps
  bit hold_req  = 1'b0;  // ask the receiver for one long hold-off

  logic [31:0] stamp;    // last timestamp offered

  pulse_interval_power_meter uut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .psel           (psel),
    .penable        (penable),
    .pwrite         (pwrite),
    .paddr          (paddr),
    .pwdata         (pwdata),
    .prdata         (prdata),
    .pready         (pready),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .timestamp_ms_i (timestamp_ms_i),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .rate_valid_o   (rate_valid_o),
    .pulse_number_o (pulse_number_o),
    .interval_ms_o  (interval_ms_o),
    .rate_centi_o   (rate_centi_o),
    .indicator_o    (indicator_o),
    .zero_interval_o(zero_interval_o)
  );

  pulse_meter_checker checker_i (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .psel           (psel),
    .penable        (penable),
    .pwrite         (pwrite),
    .paddr          (paddr),
    .pwdata         (pwdata),
    .prdata         (prdata),
    .pready         (pready),
    .in_valid_i     (in_valid_i),
    .in_ready_i     (in_ready_o),
    .timestamp_ms_i (timestamp_ms_i),
    .out_valid_i    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .rate_valid_i   (rate_valid_o),
    .pulse_number_i (pulse_number_o),
    .interval_ms_i  (interval_ms_o),
    .rate_centi_i   (rate_centi_o),
    .indicator_i    (indicator_o),
    .zero_interval_i(zero_interval_o),
    .fail_count_o   (fail_count),
    .pending_o      (pending)
  );

  initial begin
    forever #(CLK_PERIOD / 2) clk_i = ~clk_i;
  end

  // Write pulses_per_unit over APB, then read it back; the checker compares
  // the read data with its own copy of the register.
  task automatic set_pulses_per_unit(input logic [31:0] value);
    @(posedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= PPU_ADDR;
    pwdata  <= value;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    // go straight into the setup cycle of the read, psel stays high
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  // Offer one pulse beat. Drop valid only when a gap is drawn, so that
  // back-to-back beats keep valid high with no lower-and-raise in one step.
  task automatic offer_pulse(input logic [31:0] ts);
    int unsigned gap;
    gap = calm ? 0 : $urandom_range(0, MAX_WAIT);
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i     <= 1'b1;
    timestamp_ms_i <= ts;
    stamp           = ts;
    do @(posedge clk_i); while (!in_ready_o);
  endtask

  // Drop valid and hold until every predicted reading has come out.
  // Sample the pending count at the falling edge, clear of the checker update.
  task automatic drain_readings();
    in_valid_i <= 1'b0;
    do @(negedge clk_i); while (pending != 0);
  endtask

  // Pick the next timestamp: mostly short realistic intervals, some repeats
  // (zero interval), some long ones and some fully random jumps that wrap.
  function automatic logic [31:0] next_stamp(input logic [31:0] prev);
    int unsigned pick;
    pick = $urandom_range(0, 9);
    if (pick < 6)      return prev + $urandom_range(1, 3000);
    else if (pick < 7) return prev;
    else if (pick < 8) return prev + $urandom_range(3001, 50_000_000);
    else               return $urandom();
  endfunction

  // Receiver: draw a stall per beat, honor one long hold-off on request.
  initial begin
    int unsigned stall;
    wait (rst_ni);
    forever begin
      stall = calm ? 0 : $urandom_range(0, MAX_WAIT);
      if (hold_req) begin
        stall    = HOLD_CYCLES;
        hold_req = 1'b0;
      end
      if (stall > 0) begin
        out_ready_i <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      out_ready_i <= 1'b1;
      do @(posedge clk_i); while (!out_valid_o);
    end
  end

  // Stimulus and verdict
  initial begin
    logic [31:0] wdata;
    repeat (RESET_CYCLES) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Reset divisor of 100: first pulse (stored stamp stays zero), interval
    // from zero, a zero interval, the largest stamp and a wrap back past zero.
    offer_pulse(32'd0);
    offer_pulse(32'd1000);
    offer_pulse(32'd1000);
    offer_pulse(32'hFFFF_FFFF);
    offer_pulse(32'd5);
    offer_pulse(32'd6);
    drain_readings();

    // Zero divisor with junk in the upper bits: rate saturates without the flag,
    // then together with a zero interval.
    set_pulses_per_unit(32'hFFFF_C000);
    offer_pulse(32'd13);
    offer_pulse(32'd13);
    drain_readings();

    // Divisor of one: largest rate, then the largest interval.
    set_pulses_per_unit(32'd1);
    offer_pulse(32'd14);
    offer_pulse(32'd1014);
    offer_pulse(32'd1013);
    drain_readings();

    // Top of the legal range: a rate of exactly one, then just below one.
    set_pulses_per_unit(32'd10000);
    offer_pulse(32'd1014);
    offer_pulse(32'd36_001_014);
    offer_pulse(32'd72_001_015);
    drain_readings();

    // Out-of-range value, all 14 bits set.
    set_pulses_per_unit(32'hFFFF_FFFF);
    offer_pulse(32'd72_001_016);
    offer_pulse(32'd72_001_019);
    drain_readings();

    // Random phases, each under its own divisor.
    for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
      wdata = $urandom();
      case (ph)
        0: wdata = 32'd100;
        1: wdata = 32'd10000;
        2: wdata = 32'($urandom_range(1, 10000));
        default: wdata[PPU_W-1:0] = PPU_W'($urandom_range(0, 16383));
      endcase
      set_pulses_per_unit(wdata);
      calm     = (ph == 0);
      // fill the meter while the receiver holds off, stalling the input
      hold_req = (ph == 1);
      for (int n = 0; n < PHASE_PULSES; n++) begin
        offer_pulse(next_stamp(stamp));
      end
      drain_readings();
    end
    calm = 1'b0;

    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (fail_count == 0) $display("Verification passed");
    else $display("Verification failed");
    $finish;
  end

  // Watchdog: end a hung run.
  initial begin
    while (cycle_cnt < CYCLE_LIMIT) begin
      @(posedge clk_i);
      cycle_cnt++;
    end
    $display("Verification failed");
    $finish;
  end

endmodule

// ===== sim.f =====
rtl/pipm_pkg.sv
rtl/pipm_rate.sv
rtl/pulse_interval_power_meter.sv
dv/pulse_meter_checker.sv
dv/pulse_interval_power_meter_tb.sv
